[src/onot_pkg.sv]
`timescale 1ns / 1ps

package onot_pkg;

  localparam int FRAME_W = 20;
  localparam int SHIFT_W = 16;
  localparam int PROB_W  = 16;
  localparam int VEL_W   = 16;

  // config register indexes
  typedef enum logic [1:0] {
    REG_PROB_THRESHOLD = 2'd0,
    REG_MAX_NOTE_FRAMES = 2'd1,
    REG_LOWEST_NOTE = 2'd2,
    REG_VELOCITY_GAIN = 2'd3
  } cfg_reg_t;

  localparam logic [15:0] PROB_THRESHOLD_RST  = 16'd6554;
  localparam logic [15:0] MAX_NOTE_FRAMES_RST = 16'd600;
  localparam logic [6:0]  LOWEST_NOTE_RST     = 7'd21;
  localparam logic [7:0]  VELOCITY_GAIN_RST   = 8'd128;

  typedef struct packed {
    logic [15:0] prob_threshold;
    logic [15:0] max_note_frames;
    logic [6:0]  lowest_note;
    logic [7:0]  velocity_gain;
  } cfg_t;

  typedef struct packed {
    logic [6:0]         pitch;
    logic [FRAME_W-1:0] frame_index;
    logic               onset_peak;
    logic               offset_peak;
    logic [PROB_W-1:0]  frame_prob;
    logic [SHIFT_W-1:0] on_shift;
    logic [SHIFT_W-1:0] off_shift;
    logic [VEL_W-1:0]   velocity_norm;
    logic               last_frame;
  } item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [SHIFT_W-1:0] shift;
    logic [VEL_W-1:0]   velocity;
  } open_rec_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [SHIFT_W-1:0] shift;
  } off_rec_t;

  typedef struct packed {
    logic [7:0]         note_num;
    logic [FRAME_W-1:0] start_frame;
    logic [FRAME_W-1:0] end_frame;
    logic [SHIFT_W-1:0] start_shift;
    logic [SHIFT_W-1:0] end_shift;
    logic [7:0]         note_velocity;
  } note_t;

  // per-pitch state update for one word
  typedef struct packed {
    logic      open_we;
    logic      off_we;
    logic      flag_we;
    logic      open_val;
    logic      seen_val;
    open_rec_t open_rec;
    off_rec_t  off_rec;
  } upd_t;

endpackage

[src/onot_state.sv]
`timescale 1ns / 1ps

module onot_state import onot_pkg::*; #(
  parameter int NUM_PITCHES = 128,
  parameter int IW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_idx,
  input  logic [IW-1:0] cur_idx,
  input  logic [IW-1:0] wr_idx,
  input  upd_t          wr,
  output logic          open_flag,
  output logic          seen_flag,
  output open_rec_t     open_rec,
  output off_rec_t      off_rec
);

  logic [NUM_PITCHES-1:0] note_open;
  logic [NUM_PITCHES-1:0] offset_seen;

  open_rec_t open_mem [NUM_PITCHES];
  off_rec_t  off_mem [NUM_PITCHES];

  open_rec_t open_rd;
  off_rec_t  off_rd;
  logic      fwd_open;
  logic      fwd_off;
  open_rec_t fwd_open_data;
  off_rec_t  fwd_off_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      note_open <= '0;
      offset_seen <= '0;
    end else if (wr.flag_we) begin
      note_open[wr_idx] <= wr.open_val;
      offset_seen[wr_idx] <= wr.seen_val;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.open_we) begin
      open_mem[wr_idx] <= wr.open_rec;
    end
    if (wr.off_we) begin
      off_mem[wr_idx] <= wr.off_rec;
    end
    if (rd_en) begin
      open_rd <= open_mem[rd_idx];
      off_rd <= off_mem[rd_idx];
      fwd_open_data <= wr.open_rec;
      fwd_off_data <= wr.off_rec;
    end
  end

  // write and read of the same entry on one edge: take the written word
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_open <= 1'b0;
      fwd_off <= 1'b0;
    end else if (rd_en) begin
      fwd_open <= wr.open_we && (wr_idx == rd_idx);
      fwd_off <= wr.off_we && (wr_idx == rd_idx);
    end
  end

  assign open_flag = note_open[cur_idx];
  assign seen_flag = offset_seen[cur_idx];
  assign open_rec = fwd_open ? fwd_open_data : open_rd;
  assign off_rec = fwd_off ? fwd_off_data : off_rd;

endmodule

[src/onot_close.sv]
`timescale 1ns / 1ps

module onot_close import onot_pkg::*; (
  input  item_t     item,
  input  logic      in_range,
  input  logic      open_flag,
  input  logic      seen_flag,
  input  open_rec_t open_rec,
  input  off_rec_t  off_rec,
  input  cfg_t      cfg,
  output logic      res_valid,
  output note_t     res,
  output upd_t      upd
);

  logic [FRAME_W-1:0] fi;
  logic [FRAME_W-1:0] bgn;
  logic [FRAME_W-1:0] span;
  logic               seen_n;
  off_rec_t           off_n;
  logic signed [FRAME_W:0] before_d;
  logic signed [FRAME_W:0] after_d;
  logic [23:0]        vel_prod;

  assign fi = item.frame_index;
  assign bgn = open_rec.frame;
  assign span = fi - bgn;
  assign vel_prod = 24'(open_rec.velocity) * 24'(cfg.velocity_gain);

  always_comb begin
    seen_n = seen_flag;
    off_n = off_rec;
    if (item.offset_peak && !seen_flag) begin
      seen_n = 1'b1;
      off_n.frame = fi;
      off_n.shift = item.off_shift;
    end
  end

  assign before_d = $signed({1'b0, off_n.frame}) - $signed({1'b0, bgn});
  assign after_d = $signed({1'b0, fi}) - $signed({1'b0, off_n.frame});

  always_comb begin
    res_valid = 1'b0;
    res.note_num = 8'(item.pitch) + 8'(cfg.lowest_note);
    res.start_frame = open_rec.frame;
    res.end_frame = fi;
    res.start_shift = open_rec.shift;
    res.end_shift = item.off_shift;
    // product of 16 and 8 bits: top byte never exceeds 255
    res.note_velocity = vel_prod[23:16];
    upd.open_we = 1'b0;
    upd.off_we = 1'b0;
    upd.flag_we = 1'b0;
    upd.open_val = 1'b0;
    upd.seen_val = 1'b0;
    upd.open_rec.frame = fi;
    upd.open_rec.shift = item.on_shift;
    upd.open_rec.velocity = item.velocity_norm;
    upd.off_rec = off_n;
    if (in_range) begin
      if (item.onset_peak) begin
        // re-onset closes the open note one frame early
        res_valid = open_flag;
        res.end_frame = (fi == '0) ? '0 : fi - 1'b1;
        res.end_shift = '0;
        upd.open_we = 1'b1;
        upd.flag_we = 1'b1;
        upd.open_val = 1'b1;
        upd.seen_val = 1'b0;
      end else if (open_flag && (fi > bgn)) begin
        upd.off_we = item.offset_peak && !seen_flag;
        upd.flag_we = 1'b1;
        upd.open_val = 1'b1;
        upd.seen_val = seen_n;
        if (item.frame_prob <= cfg.prob_threshold) begin
          res_valid = 1'b1;
          upd.open_val = 1'b0;
          upd.seen_val = 1'b0;
          if (seen_n && (before_d > after_d)) begin
            res.end_frame = off_n.frame;
            res.end_shift = off_n.shift;
          end
        end else if ((span >= FRAME_W'(cfg.max_note_frames)) || item.last_frame) begin
          res_valid = 1'b1;
          upd.open_val = 1'b0;
          upd.seen_val = 1'b0;
        end
      end
    end
  end

endmodule

[src/onset_offset_note_tracker.sv]
`timescale 1ns / 1ps

// onset/offset note tracker, one word per pitch per frame
// s_* channel: one pitch-frame word, last_frame on s_tlast
// m_* channel: one finished note, emitted only when a note closes
// cfg_* channel: register writes, always ready; the user must write only while
//   the block is idle, which the block itself does not enforce
// pipeline: input register with per-pitch state read, then the note decision
//   and the state write-back feed the result register
// throughput: one word per cycle unless the result side stalls; state is read
//   at the accepting edge and a same-pitch write on that edge is forwarded,
//   so back-to-back words of one pitch need no bubble
// reset: all notes closed, no offset recorded, registers take defaults,
//   pipeline empty; note data memories are not cleared
// stall: while m_tready is low and a note waits, the input register holds
//   and s_tready drops only once that register is also full
// out-of-range pitch words are accepted and dropped

module onset_offset_note_tracker import onot_pkg::*; #(
  parameter int NUM_PITCHES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // pitch, frame_index, onset_peak, offset_peak, frame_prob, on_shift,
  // off_shift, velocity_norm, zero pad
  input  logic [95:0] s_tdata,
  // last_frame
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // note_num, start_frame, end_frame, start_shift, end_shift, note_velocity
  output logic [87:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IW = (NUM_PITCHES > 1) ? $clog2(NUM_PITCHES) : 1;

  cfg_t  cfg;
  item_t in_item;
  logic  s_accept;
  logic  advance;

  // input stage
  logic  s1_valid;
  item_t s1;
  logic  s1_in_range;

  // result stage
  note_t out_note;

  logic      open_flag;
  logic      seen_flag;
  open_rec_t open_rec;
  off_rec_t  off_rec;
  logic      res_valid;
  note_t     res;
  upd_t      upd;
  upd_t      wr;

  logic [7:0]    in_pitch8;
  logic [7:0]    s1_pitch8;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] cur_idx;

  // unpack the incoming word
  always_comb begin
    in_item.pitch = s_tdata[6:0];
    in_item.frame_index = s_tdata[26:7];
    in_item.onset_peak = s_tdata[27];
    in_item.offset_peak = s_tdata[28];
    in_item.frame_prob = s_tdata[44:29];
    in_item.on_shift = s_tdata[60:45];
    in_item.off_shift = s_tdata[76:61];
    in_item.velocity_norm = s_tdata[92:77];
    in_item.last_frame = s_tlast;
  end

  assign advance = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  assign in_pitch8 = {1'b0, in_item.pitch};
  assign s1_pitch8 = {1'b0, s1.pitch};
  assign rd_idx = in_pitch8[IW-1:0];
  assign cur_idx = s1_pitch8[IW-1:0];

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prob_threshold <= PROB_THRESHOLD_RST;
      cfg.max_note_frames <= MAX_NOTE_FRAMES_RST;
      cfg.lowest_note <= LOWEST_NOTE_RST;
      cfg.velocity_gain <= VELOCITY_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PROB_THRESHOLD: cfg.prob_threshold <= cfg_data;
        REG_MAX_NOTE_FRAMES: cfg.max_note_frames <= cfg_data;
        REG_LOWEST_NOTE: cfg.lowest_note <= cfg_data[6:0];
        REG_VELOCITY_GAIN: cfg.velocity_gain <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1 <= in_item;
      s1_in_range <= (9'(in_pitch8) < 9'(NUM_PITCHES));
    end
  end

  // state writes land only when the word leaves the input register
  always_comb begin
    wr = upd;
    wr.open_we = upd.open_we && advance;
    wr.off_we = upd.off_we && advance;
    wr.flag_we = upd.flag_we && advance;
  end

  onot_state #(
    .NUM_PITCHES(NUM_PITCHES),
    .IW(IW)
  ) u_state (
    .clk(clk),
    .rst(rst),
    .rd_en(s_accept),
    .rd_idx(rd_idx),
    .cur_idx(cur_idx),
    .wr_idx(cur_idx),
    .wr(wr),
    .open_flag(open_flag),
    .seen_flag(seen_flag),
    .open_rec(open_rec),
    .off_rec(off_rec)
  );

  onot_close u_close (
    .item(s1),
    .in_range(s1_in_range),
    .open_flag(open_flag),
    .seen_flag(seen_flag),
    .open_rec(open_rec),
    .off_rec(off_rec),
    .cfg(cfg),
    .res_valid(res_valid),
    .res(res),
    .upd(upd)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_note <= res;
    end
  end

  assign m_tdata = {out_note.note_velocity, out_note.end_shift, out_note.start_shift,
                    out_note.end_frame, out_note.start_frame, out_note.note_num};

`ifndef SYNTH
  // an empty input register always takes a word
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> s_tready)
    else $error("input register empty but not ready");

  // a closing word always shows up on the result side
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (advance && res_valid) |=> m_tvalid)
    else $error("closed note not presented");

  // a waiting note is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !advance)
    else $error("pending note overwritten");

  // no state write without a word leaving the input register
  a_write_gated: assert property (@(posedge clk) disable iff (rst)
    (wr.flag_we || wr.open_we || wr.off_we) |-> advance)
    else $error("state written while stalled");
`endif

endmodule

[sim/note_checker.sv]
`timescale 1ns / 1ps

module note_checker import onot_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [95:0] s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [87:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          pending,
  output int          mismatches
);

  cfg_t cfg;

  // per-pitch note state
  bit                 is_open       [128];
  logic [FRAME_W-1:0] onset_frame_q [128];
  logic [SHIFT_W-1:0] onset_shift_q [128];
  logic [VEL_W-1:0]   onset_vel_q   [128];
  bit                 off_seen      [128];
  logic [FRAME_W-1:0] off_frame_q   [128];
  logic [SHIFT_W-1:0] off_shift_q   [128];

  note_t notes_due [$];
  note_t got, want;

  initial begin
    pending = 0;
    mismatches = 0;
  end

  function automatic note_t close_note(input int p, input logic [FRAME_W-1:0] end_f,
                                       input logic [SHIFT_W-1:0] end_sh);
    note_t n;
    logic [23:0] prod;
    prod = 24'(onset_vel_q[p]) * 24'(cfg.velocity_gain);
    n.note_num = 8'(p) + 8'(cfg.lowest_note);
    n.start_frame = onset_frame_q[p];
    n.end_frame = end_f;
    n.start_shift = onset_shift_q[p];
    n.end_shift = end_sh;
    // 16x8 product shifted by 16 never exceeds 255
    n.note_velocity = prod[23:16];
    return n;
  endfunction

  function automatic void track_word(input logic [95:0] d, input logic fin);
    item_t w;
    int p;
    logic [FRAME_W-1:0] span;
    logic [FRAME_W-1:0] back_f;
    longint lead, tail;
    w.pitch = d[6:0];
    w.frame_index = d[26:7];
    w.onset_peak = d[27];
    w.offset_peak = d[28];
    w.frame_prob = d[44:29];
    w.on_shift = d[60:45];
    w.off_shift = d[76:61];
    w.velocity_norm = d[92:77];
    w.last_frame = fin;
    p = int'(w.pitch);

    // re-onset closes the open note one frame back
    if (w.onset_peak) begin
      if (is_open[p]) begin
        back_f = (w.frame_index == '0) ? '0 : w.frame_index - 1'b1;
        notes_due.insert(notes_due.size(), close_note(p, back_f, '0));
      end
      onset_frame_q[p] = w.frame_index;
      onset_shift_q[p] = w.on_shift;
      onset_vel_q[p] = w.velocity_norm;
      off_seen[p] = 1'b0;
      is_open[p] = 1'b1;
    end

    if (is_open[p] && w.frame_index > onset_frame_q[p]) begin
      if (w.offset_peak && !off_seen[p]) begin
        off_seen[p] = 1'b1;
        off_frame_q[p] = w.frame_index;
        off_shift_q[p] = w.off_shift;
      end
      if (w.frame_prob <= cfg.prob_threshold) begin
        // end at the offset when it lies past the midpoint
        lead = longint'(off_frame_q[p]) - longint'(onset_frame_q[p]);
        tail = longint'(w.frame_index) - longint'(off_frame_q[p]);
        if (off_seen[p] && lead > tail)
          notes_due.insert(notes_due.size(), close_note(p, off_frame_q[p], off_shift_q[p]));
        else
          notes_due.insert(notes_due.size(), close_note(p, w.frame_index, w.off_shift));
        is_open[p] = 1'b0;
        off_seen[p] = 1'b0;
      end else begin
        span = w.frame_index - onset_frame_q[p];
        if (span >= FRAME_W'(cfg.max_note_frames) || w.last_frame) begin
          notes_due.insert(notes_due.size(), close_note(p, w.frame_index, w.off_shift));
          is_open[p] = 1'b0;
          off_seen[p] = 1'b0;
        end
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [19:0] exp_v,
                                      input logic [19:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg.prob_threshold = PROB_THRESHOLD_RST;
      cfg.max_note_frames = MAX_NOTE_FRAMES_RST;
      cfg.lowest_note = LOWEST_NOTE_RST;
      cfg.velocity_gain = VELOCITY_GAIN_RST;
      for (int i = 0; i < 128; i++) begin
        is_open[i] = 1'b0;
        off_seen[i] = 1'b0;
        onset_frame_q[i] = '0;
        onset_shift_q[i] = '0;
        onset_vel_q[i] = '0;
        off_frame_q[i] = '0;
        off_shift_q[i] = '0;
      end
      notes_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_PROB_THRESHOLD: cfg.prob_threshold = cfg_data;
          REG_MAX_NOTE_FRAMES: cfg.max_note_frames = cfg_data;
          REG_LOWEST_NOTE: cfg.lowest_note = cfg_data[6:0];
          REG_VELOCITY_GAIN: cfg.velocity_gain = cfg_data[7:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.note_num = m_tdata[7:0];
        got.start_frame = m_tdata[27:8];
        got.end_frame = m_tdata[47:28];
        got.start_shift = m_tdata[63:48];
        got.end_shift = m_tdata[79:64];
        got.note_velocity = m_tdata[87:80];
        if (notes_due.size() == 0) begin
          $error("note with none expected: %h", m_tdata);
          mismatches++;
        end else begin
          want = notes_due.pop_front();
          check_field("note_num", 20'(want.note_num), 20'(got.note_num));
          check_field("start_frame", want.start_frame, got.start_frame);
          check_field("end_frame", want.end_frame, got.end_frame);
          check_field("start_shift", 20'(want.start_shift), 20'(got.start_shift));
          check_field("end_shift", 20'(want.end_shift), 20'(got.end_shift));
          check_field("note_velocity", 20'(want.note_velocity), 20'(got.note_velocity));
        end
      end
      if (s_tvalid && s_tready)
        track_word(s_tdata, s_tlast);
    end
    pending = notes_due.size();
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
  import onot_pkg::*;

  // longest quiet stretch of a correct run: the long receiver hold plus the
  // longest sender gap plus the drain pause; this is several times that
  localparam int STALL_LIMIT = 4000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // pitch, frame_index, onset_peak, offset_peak, frame_prob, on_shift,
  // off_shift, velocity_norm, zero pad
  logic [95:0] s_tdata;
  // last_frame
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  // note_num, start_frame, end_frame, start_shift, end_shift, note_velocity
  logic [87:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int pending;
  int mismatches;
  int quiet;

  // stimulus shaping state
  bit          busy_phase;
  logic [15:0] cur_thr;
  bit          ringing    [128];
  logic [19:0] next_frame [128];

  onset_offset_note_tracker dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  note_checker chk (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pending(pending),
    .mismatches(mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly back-to-back words, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (busy_phase)
      return 0;
    r = $urandom_range(99);
    if (r < 65)
      return 0;
    if (r < 95)
      return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // a probability that keeps a note sounding under the current threshold; none does at 16'hFFFF
  function automatic logic [15:0] prob_above();
    if (cur_thr == 16'hFFFF)
      return 16'hFFFF;
    return 16'($urandom_range(65535, int'(cur_thr) + 1));
  endfunction

  // a probability that ends a note
  function automatic logic [15:0] prob_low();
    return 16'($urandom_range(int'(cur_thr), 0));
  endfunction

  // offer one word, hold it until taken; entered and left at a falling edge
  task automatic send_word(input logic [6:0] pitch, input logic [19:0] frame,
                           input bit on, input bit off, input logic [15:0] prob,
                           input logic [15:0] onsh, input logic [15:0] offsh,
                           input logic [15:0] vel, input bit fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata <= {3'b000, vel, offsh, onsh, prob, off, on, frame, pitch};
    s_tlast <= fin;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic setup(input logic [15:0] thr, input logic [15:0] maxf,
                       input logic [6:0] low, input logic [7:0] gain);
    cur_thr = thr;
    write_reg(REG_PROB_THRESHOLD, thr);
    write_reg(REG_MAX_NOTE_FRAMES, maxf);
    write_reg(REG_LOWEST_NOTE, {9'd0, low});
    write_reg(REG_VELOCITY_GAIN, {8'd0, gain});
  endtask

  // wait for every predicted note, then let words that close nothing leave
  // the two-stage pipeline before touching registers
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // one word of a plausible note life for pitch p
  task automatic shaped_word(input logic [6:0] p, input bit fin);
    logic [19:0] frame;
    bit on, off;
    logic [15:0] prob;
    frame = next_frame[p];
    next_frame[p] = frame + (($urandom_range(9) == 0) ? 20'($urandom_range(4, 2)) : 20'd1);
    on = ringing[p] ? ($urandom_range(19) == 0) : ($urandom_range(3) == 0);
    off = ($urandom_range(5) == 0);
    if (on) begin
      ringing[p] = 1'b1;
      prob = prob_above();
    end else if (ringing[p] && $urandom_range(7) != 0) begin
      prob = prob_above();
    end else begin
      ringing[p] = 1'b0;
      prob = prob_low();
    end
    if (fin)
      ringing[p] = 1'b0;
    send_word(p, frame, on, off, prob, 16'($urandom), 16'($urandom), 16'($urandom), fin);
  endtask

  // streams of frames over a few pitches, with some fully random words mixed in; a
  // stream ends on a last frame unless a random word or the end of the phase cuts it
  task automatic run_phase(input int count);
    int sent, frames_left, nvoice;
    logic [6:0] voices [6];
    sent = 0;
    frames_left = 0;
    nvoice = 1;
    while (sent < count) begin
      if (frames_left == 0) begin
        nvoice = $urandom_range(6, 1);
        frames_left = $urandom_range(60, 5);
        for (int v = 0; v < nvoice; v++) begin
          voices[v] = 7'($urandom);
          // now and then start near the top of the frame range so it wraps
          next_frame[voices[v]] = ($urandom_range(7) == 0) ?
                                  20'hFFFFF - 20'($urandom_range(20)) : 20'($urandom);
        end
      end
      for (int v = 0; v < nvoice; v++) begin
        if ($urandom_range(99) < 12)
          send_word(7'($urandom), 20'($urandom), 1'($urandom_range(1)),
                    1'($urandom_range(1)), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 1'($urandom_range(1)));
        else
          shaped_word(voices[v], frames_left == 1);
        sent++;
      end
      frames_left--;
    end
  endtask

  // receiver: random ready runs, plus two long holds to back the block up
  initial begin
    int run_left, taken;
    bit run_val;
    int r;
    m_tready = 1'b0;
    run_left = 0;
    taken = 0;
    run_val = 1'b0;
    forever begin
      @(negedge clk);
      if (run_left == 0) begin
        r = $urandom_range(99);
        if (r < 50) begin
          run_val = 1'b1;
          run_left = $urandom_range(8, 1);
        end else if (r < 55) begin
          run_val = 1'b1;
          run_left = $urandom_range(200, 100);
        end else if (r < 93) begin
          run_val = 1'b0;
          run_left = $urandom_range(3, 1);
        end else begin
          run_val = 1'b0;
          run_left = $urandom_range(60, 10);
        end
      end
      m_tready <= run_val;
      run_left--;
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        taken++;
        // sender keeps offering meanwhile, so the input side must stall
        if (taken == 40 || taken == 300) begin
          run_val = 1'b0;
          run_left = 400;
        end
      end
    end
  end

  // watchdog on cycles with no word moving anywhere
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_PROB_THRESHOLD;
    cfg_data = '0;
    busy_phase = 1'b0;
    cur_thr = PROB_THRESHOLD_RST;
    for (int i = 0; i < 128; i++) begin
      ringing[i] = 1'b0;
      next_frame[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: short max length, top lowest note, top gain
    setup(16'd6554, 16'd4, 7'd127, 8'd255);
    // onset at frame zero, then re-onset there: end frame clamps to zero
    send_word(7'd0, 20'd0, 1, 0, 16'hFFFF, 16'h8000, 16'h0000, 16'hFFFF, 0);
    send_word(7'd0, 20'd0, 1, 0, 16'hFFFF, 16'h7FFF, 16'h1111, 16'h0000, 0);
    // offset not past the midpoint: ends at the falling frame
    send_word(7'd0, 20'd1, 0, 1, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h0000, 0);
    send_word(7'd0, 20'd2, 0, 0, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 0);
    // offset past the midpoint: ends at the offset with its kept shift,
    // second offset peak ignored, probability equal to threshold closes
    send_word(7'd1, 20'd10, 1, 0, 16'hFFFF, 16'h0123, 16'h0000, 16'h8000, 0);
    send_word(7'd1, 20'd12, 0, 1, 16'd40000, 16'h0000, 16'h1234, 16'h0000, 0);
    send_word(7'd1, 20'd13, 0, 1, 16'd6554, 16'h0000, 16'h4321, 16'h0000, 0);
    // maximum length reached
    send_word(7'd2, 20'd20, 1, 0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h1234, 0);
    send_word(7'd2, 20'd24, 0, 0, 16'hFFFF, 16'h0000, 16'h5555, 16'h0000, 0);
    // last frame on the onset frame keeps the note, next last frame closes it
    send_word(7'd3, 20'd30, 1, 0, 16'hFFFF, 16'h0001, 16'h0000, 16'hAAAA, 1);
    send_word(7'd3, 20'd31, 0, 0, 16'd6555, 16'h0000, 16'hAAAA, 16'h0000, 1);
    // top frame, a frame going backwards, re-onsets across the wrap
    send_word(7'd127, 20'hFFFFF, 1, 0, 16'hFFFF, 16'h7FFF, 16'h0000, 16'h0000, 0);
    send_word(7'd127, 20'hFFFFE, 0, 1, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 0);
    send_word(7'd127, 20'hFFFFF, 1, 0, 16'hFFFF, 16'h8001, 16'h0000, 16'h5A5A, 0);
    send_word(7'd127, 20'd5, 1, 0, 16'hFFFF, 16'h2222, 16'h0000, 16'hFFFF, 0);
    // just above threshold holds, at threshold closes
    send_word(7'd127, 20'd6, 0, 0, 16'd6555, 16'h0000, 16'h3333, 16'h0000, 0);
    send_word(7'd127, 20'd7, 0, 0, 16'd6554, 16'h0000, 16'h4444, 16'h0000, 0);
    // offset peak with no open note does nothing
    send_word(7'd64, 20'd0, 0, 1, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1);
    drain();

    // random phases across register extremes
    busy_phase = 1'b0;
    setup(PROB_THRESHOLD_RST, MAX_NOTE_FRAMES_RST, LOWEST_NOTE_RST, VELOCITY_GAIN_RST);
    run_phase(310);
    drain();

    // among probabilities only zero ends a note, gain of one, no idling
    busy_phase = 1'b1;
    setup(16'd0, 16'hFFFF, 7'd0, 8'd1);
    run_phase(310);
    drain();

    // every later frame closes, zero max length and zero gain
    busy_phase = 1'b0;
    setup(16'hFFFF, 16'd0, 7'd127, 8'd0);
    run_phase(310);
    drain();

    setup(16'($urandom), 16'($urandom_range(20, 1)), 7'($urandom), 8'($urandom));
    run_phase(310);
    drain();

    busy_phase = 1'b1;
    setup(16'd32768, 16'd1, 7'd64, 8'd255);
    run_phase(310);
    drain();

    busy_phase = 1'b0;
    setup(16'($urandom), 16'($urandom), 7'($urandom), 8'($urandom));
    run_phase(310);
    drain();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
src/onot_pkg.sv
src/onot_state.sv
src/onot_close.sv
src/onset_offset_note_tracker.sv
sim/note_checker.sv
sim/tb.sv
